@@ design/shc_pkg.sv @@
package shc_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
    localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

    localparam logic [63:0] MagicReset  = 64'd0;
    localparam logic [15:0] MajorReset  = 16'd0;
    localparam logic [31:0] MaxLenReset = 32'd1048576;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_MAJOR   = 2'd1,
        REG_MAX_LEN = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_MAJOR = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_CRC_ERR   = 3'd4
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [63:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [15:0] minor_version;
        logic [31:0] metadata_length;
        logic [31:0] computed_crc;
        logic        last;
    } t_result;

endpackage

@@ design/shc_front.sv @@
module shc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  shc_pkg::t_cfg_wr i_cfg,
    input  logic             i_valid,
    input  logic             i_restart,
    input  logic [7:0]       i_byte,
    input  logic             i_q_full,
    output logic             o_ready,
    output logic             o_push,
    output shc_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_MAGIC, PH_MAJOR, PH_MINOR, PH_LENGTH, PH_META, PH_CHECK, PH_IDLE
    } t_phase;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (x[0] ? shc_pkg::CrcPoly : 32'd0);
        end
        return x;
    endfunction

    logic [63:0] r_magic;
    logic [15:0] r_major_exp;
    logic [31:0] r_max_len;

    t_phase      r_phase, n_phase, c_phase;
    logic [31:0] r_count, n_count, c_count;
    logic [63:0] r_field, n_field, c_field;
    logic [31:0] r_crc, n_crc, c_crc;
    logic [31:0] r_len, n_len, c_len;
    logic [15:0] r_minor, n_minor, c_minor;
    logic [15:0] r_major, n_major, c_major;

    logic [63:0] field_set;
    logic [31:0] count_inc;
    logic        accept;
    logic        emit;
    logic        fin;
    shc_pkg::t_status fin_status;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;

    // a restart beat behaves as if the header state had just been cleared
    always_comb begin
        if (i_restart) begin
            c_phase = PH_MAGIC;
            c_count = 32'd0;
            c_field = 64'd0;
            c_crc   = shc_pkg::CrcOnes;
            c_len   = 32'd0;
            c_minor = 16'd0;
            c_major = 16'd0;
        end else begin
            c_phase = r_phase;
            c_count = r_count;
            c_field = r_field;
            c_crc   = r_crc;
            c_len   = r_len;
            c_minor = r_minor;
            c_major = r_major;
        end
    end

    always_comb begin
        field_set = c_field;
        field_set[c_count[2:0]*8 +: 8] = i_byte;
        count_inc = c_count + 32'd1;

        n_phase = c_phase;
        n_count = count_inc;
        n_field = field_set;
        n_crc   = c_crc;
        n_len   = c_len;
        n_minor = c_minor;
        n_major = c_major;
        emit    = 1'b0;
        fin     = 1'b0;
        fin_status = shc_pkg::ST_OK;

        case (c_phase)
            PH_MAGIC: begin
                if (count_inc == 32'd8) begin
                    n_count = 32'd0;
                    n_field = 64'd0;
                    if (field_set != r_magic) begin
                        fin = 1'b1;
                        fin_status = shc_pkg::ST_BAD_MAGIC;
                    end else begin
                        n_phase = PH_MAJOR;
                    end
                end
            end
            PH_MAJOR: begin
                if (count_inc == 32'd2) begin
                    n_count = 32'd0;
                    n_field = 64'd0;
                    n_major = field_set[15:0];
                    n_phase = PH_MINOR;
                end
            end
            PH_MINOR: begin
                if (count_inc == 32'd2) begin
                    n_count = 32'd0;
                    n_field = 64'd0;
                    n_minor = field_set[15:0];
                    if (c_major != r_major_exp) begin
                        fin = 1'b1;
                        fin_status = shc_pkg::ST_BAD_MAJOR;
                    end else begin
                        n_phase = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                if (count_inc == 32'd8) begin
                    n_count = 32'd0;
                    n_field = 64'd0;
                    n_len   = field_set[31:0];
                    if (field_set[63:32] != 32'd0 || field_set[31:0] > r_max_len) begin
                        fin = 1'b1;
                        fin_status = shc_pkg::ST_TOO_LONG;
                    end else if (field_set[31:0] == 32'd0) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_META;
                    end
                end
            end
            PH_META: begin
                n_field = c_field;
                n_crc   = crc_step(c_crc, i_byte);
                emit    = 1'b1;
                if (count_inc >= c_len) begin
                    n_count = 32'd0;
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (count_inc == 32'd4) begin
                    n_count = 32'd0;
                    n_field = 64'd0;
                    fin = 1'b1;
                    fin_status = (field_set[31:0] != ~c_crc) ? shc_pkg::ST_CRC_ERR
                                                            : shc_pkg::ST_OK;
                end
            end
            default: begin
                // finished header: bytes are dropped until restart
                n_count = c_count;
                n_field = c_field;
            end
        endcase

        if (fin) begin
            n_phase = PH_IDLE;
            emit    = 1'b1;
        end

        o_res.kind            = fin;
        o_res.payload_byte    = fin ? 8'd0 : i_byte;
        o_res.status          = fin_status;
        o_res.minor_version   = n_minor;
        o_res.metadata_length = n_len;
        o_res.computed_crc    = ~n_crc;
        o_res.last            = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic     <= shc_pkg::MagicReset;
            r_major_exp <= shc_pkg::MajorReset;
            r_max_len   <= shc_pkg::MaxLenReset;
            r_phase     <= PH_MAGIC;
            r_count     <= 32'd0;
            r_field     <= 64'd0;
            r_crc       <= shc_pkg::CrcOnes;
            r_len       <= 32'd0;
            r_minor     <= 16'd0;
            r_major     <= 16'd0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    shc_pkg::REG_MAGIC:   r_magic     <= i_cfg.data;
                    shc_pkg::REG_MAJOR:   r_major_exp <= i_cfg.data[15:0];
                    shc_pkg::REG_MAX_LEN: r_max_len   <= i_cfg.data[31:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_field <= n_field;
                r_crc   <= n_crc;
                r_len   <= n_len;
                r_minor <= n_minor;
                r_major <= n_major;
            end
        end
    end

endmodule

@@ design/shc_queue.sv @@
module shc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  shc_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output shc_pkg::t_result o_res
);

    shc_pkg::t_result r_mem [shc_pkg::QDepth];

    logic [shc_pkg::QAw-1:0] r_wr_ptr;
    logic [shc_pkg::QAw-1:0] r_rd_ptr;
    logic [shc_pkg::QAw:0]   r_count;
    logic                    pop;

    assign o_full  = (r_count == (shc_pkg::QAw+1)'(shc_pkg::QDepth));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/stream_header_checker_unit.sv @@
// Header checker: one header byte per beat on the slave stream, accepted every cycle
// while the 4-deep result queue has room, so a byte may follow in the next cycle. The
// parser updates magic/version/length fields and a byte-wide CRC-32 in the cycle the byte
// is taken; each metadata byte and the final status appear on the master stream in the next
// cycle at the earliest, and the queue lets the parser keep going while the master side
// stalls, until four results are waiting. Config writes are taken every cycle and should
// only be issued while no header is in flight.
module stream_header_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [26:11] minor_version,
    // [58:27] metadata_length, [90:59] computed_crc, [95:91] zero
    output logic [95:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast
);

    shc_pkg::t_cfg_wr cfg_wr;
    shc_pkg::t_result fr_res;
    shc_pkg::t_result q_res;
    logic             push;
    logic             q_full;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    shc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_wr),
        .i_valid   (s_axis_tvalid),
        .i_restart (s_axis_tuser),
        .i_byte    (s_axis_tdata),
        .i_q_full  (q_full),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_res     (fr_res)
    );

    shc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (fr_res),
        .o_full  (q_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (q_res)
    );

    assign m_axis_tdata = {5'd0, q_res.computed_crc, q_res.metadata_length,
                           q_res.minor_version, q_res.status, q_res.payload_byte};
    assign m_axis_tuser = q_res.kind;
    assign m_axis_tlast = q_res.last;

endmodule

@@ design/shc_checker.sv @@
module shc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // the status beat is always the one that closes a header
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast and status kind disagree");

    a_meta_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[10:8] == 3'd0))
        else $error("metadata beat carries a status code");

    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("status beat carries a payload byte");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:8] <= 3'd4 && m_axis_tdata[95:91] == 5'd0))
        else $error("status code or padding out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled beat changed");

endmodule

bind stream_header_checker_unit shc_checker u_shc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
